// File: design/dsss_pkg.sv
// Package: shared constants, codes and types of the servo switch sequencer.
`timescale 1ns / 1ps
package dsss_pkg;

    localparam int CHANNELS_DEF = 3;

    localparam int CH_FW    = 2;
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;
    localparam int ANGLE_W  = 8;
    localparam int POS_W    = 2;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [POS_W-1:0] POS_NEUTRAL = 2'd0;
    localparam logic [POS_W-1:0] POS_ON      = 2'd1;
    localparam logic [POS_W-1:0] POS_OFF     = 2'd2;

    localparam logic [ANGLE_W-1:0] ANGLE_ON      = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_NEUTRAL = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_OFF     = 8'd180;

    localparam logic [CFG_IX_W-1:0] REG_OFF_FLOOR  = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_ON_THRESH  = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_MOVE_DELAY = 2'd2;

    localparam logic [LEVEL_W-1:0] OFF_FLOOR_RST  = 8'd2;
    localparam logic [LEVEL_W-1:0] ON_THRESH_RST  = 8'd127;
    localparam logic [DELAY_W-1:0] MOVE_DELAY_RST = 16'd2500;

    typedef struct packed {
        logic [LEVEL_W-1:0] off_floor;
        logic [LEVEL_W-1:0] on_threshold;
        logic [DELAY_W-1:0] move_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic               in_range;
        logic [CH_FW-1:0]   channel;
        logic [POS_W-1:0]   req;
        logic [TIME_W-1:0]  now_ms;
    } t_qitem;

    typedef struct packed {
        logic [CH_FW-1:0]   out_channel;
        logic               drive_valid;
        logic [ANGLE_W-1:0] drive_angle;
        logic [POS_W-1:0]   requested_position;
    } t_result;

endpackage

// File: design/dsss_if.sv
// Interfaces: sample input channel, result output channel and register write channel.
`timescale 1ns / 1ps
interface dsss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [7:0]  dmx_level;
    logic [31:0] now_ms;
    modport source(output valid, channel, dmx_level, now_ms, input ready);
    modport sink(input valid, channel, dmx_level, now_ms, output ready);
endinterface

interface dsss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_channel;
    logic       drive_valid;
    logic [7:0] drive_angle;
    logic [1:0] requested_position;
    modport source(output valid, out_channel, drive_valid, drive_angle, requested_position,
                   input ready);
    modport sink(input valid, out_channel, drive_valid, drive_angle, requested_position,
                 output ready);
endinterface

interface dsss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: design/dsss_front.sv
// Front end: accept samples, decode the DMX level into a request, push to the queue.
`timescale 1ns / 1ps
module dsss_front #(
    parameter int CHANNELS = dsss_pkg::CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dsss_in_if.sink         i_in,
    input  dsss_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output dsss_pkg::t_qitem o_item
);
    import dsss_pkg::*;

    localparam int IX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [POS_W-1:0] r_last [CHANNELS];
    logic [IX_W-1:0]  ix;
    logic             in_range;
    logic [POS_W-1:0] req;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign in_range   = {{(32-CH_FW){1'b0}}, i_in.channel} < 32'(CHANNELS);
    assign ix         = IX_W'(i_in.channel);

    always_comb begin
        req = POS_NEUTRAL;
        if (in_range) begin
            if (i_in.dmx_level > i_cfg.off_floor && i_in.dmx_level < i_cfg.on_threshold) begin
                req = POS_OFF;
            end else if (i_in.dmx_level >= i_cfg.on_threshold) begin
                req = POS_ON;
            end else begin
                req = r_last[ix];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_last[c] <= POS_NEUTRAL;
            end
        end else if (o_push && in_range) begin
            r_last[ix] <= req;
        end
    end

    assign o_item.in_range = in_range;
    assign o_item.channel  = i_in.channel;
    assign o_item.req      = req;
    assign o_item.now_ms   = i_in.now_ms;

endmodule

// File: design/dsss_queue.sv
// Two-entry queue between the decode front end and the sequencer back end.
`timescale 1ns / 1ps
module dsss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dsss_pkg::t_qitem i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output dsss_pkg::t_qitem o_item
);
    import dsss_pkg::*;

    t_qitem     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> (r_wptr == r_rptr))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("full queue with unequal pointers");

endmodule

// File: design/dsss_back.sv
// Back end: per-channel move, neutral and lockout sequencer with the result register.
`timescale 1ns / 1ps
module dsss_back #(
    parameter int CHANNELS = dsss_pkg::CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dsss_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  dsss_pkg::t_qitem i_item,
    output logic             o_pop,
    dsss_out_if.source       o_result
);
    import dsss_pkg::*;

    localparam int IX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [POS_W-1:0]  r_sw   [CHANNELS];
    logic [TIME_W-1:0] r_due  [CHANNELS];
    logic [TIME_W-1:0] r_lock [CHANNELS];
    logic              r_out_valid;
    t_result           r_out;

    logic [IX_W-1:0]   ix;
    logic [TIME_W-1:0] due, lock, sum;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] n_due, n_lock;
    logic [POS_W-1:0]  n_sw;
    t_result           n_out;

    assign ix    = IX_W'(i_item.channel);
    assign o_pop = i_q_valid && (!r_out_valid || o_result.ready);
    assign sum   = i_item.now_ms + {{(TIME_W-DELAY_W){1'b0}}, i_cfg.move_delay_ms};

    always_comb begin
        due  = r_due[ix];
        lock = r_lock[ix];
        pos  = r_sw[ix];
        n_due  = due;
        n_lock = lock;
        n_sw   = pos;
        n_out.out_channel        = i_item.channel;
        n_out.drive_valid        = 1'b0;
        n_out.drive_angle        = ANGLE_ON;
        n_out.requested_position = i_item.req;
        if (i_item.in_range) begin
            if (lock != '0 && lock < i_item.now_ms) begin
                n_lock = '0;
                n_due  = '0;
            end else if (due != '0 && due < i_item.now_ms && lock == '0) begin
                n_lock            = sum;
                n_out.drive_valid = 1'b1;
                n_out.drive_angle = ANGLE_NEUTRAL;
            end
            if (i_item.req != POS_NEUTRAL && i_item.req != pos && n_due == '0) begin
                n_due             = sum;
                n_sw              = i_item.req;
                n_out.drive_valid = 1'b1;
                n_out.drive_angle = (i_item.req == POS_ON) ? ANGLE_ON : ANGLE_OFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sw[c]   <= POS_NEUTRAL;
                r_due[c]  <= '0;
                r_lock[c] <= '0;
            end
        end else if (o_pop && i_item.in_range) begin
            r_sw[ix]   <= n_sw;
            r_due[ix]  <= n_due;
            r_lock[ix] <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.out_channel        = r_out.out_channel;
    assign o_result.drive_valid        = r_out.drive_valid;
    assign o_result.drive_angle        = r_out.drive_angle;
    assign o_result.requested_position = r_out.requested_position;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.drive_valid) |-> (r_out.drive_angle == ANGLE_ON))
        else $error("angle set without a drive command");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.drive_valid && r_out.drive_angle == ANGLE_OFF)
            |-> (r_out.requested_position == POS_OFF))
        else $error("off drive without off request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped item not registered");

endmodule

// File: design/dmx_servo_switch_sequencer.sv
// Top level: register file, decode front end, queue and sequencer back end.
//
//  channel   role    payload                                          accepted when
//  i_in      sink    channel, dmx_level, now_ms                       valid && ready
//  o_result  source  out_channel, drive_valid, drive_angle, req. pos  valid && ready
//  i_cfg     sink    index, data                                      valid (ready is 1)
//
// One item per cycle sustained while o_result is not stalled; each taken item is
// written to a queue entry, then popped straight into the result register. The
// per-channel state update in the back end sets this rate. Reset clears the queue,
// all channel state and the registers to their defaults. A stalled output fills the
// two-entry queue, then drops i_in.ready.
`timescale 1ns / 1ps
module dmx_servo_switch_sequencer #(
    parameter int CHANNELS = dsss_pkg::CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsss_in_if.sink    i_in,
    dsss_out_if.source o_result,
    dsss_cfg_if.sink   i_cfg
);
    import dsss_pkg::*;

    t_cfg   r_cfg;
    logic   q_full, q_valid, push, pop;
    t_qitem f_item, q_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_floor     <= OFF_FLOOR_RST;
            r_cfg.on_threshold  <= ON_THRESH_RST;
            r_cfg.move_delay_ms <= MOVE_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OFF_FLOOR:  r_cfg.off_floor     <= i_cfg.data[LEVEL_W-1:0];
                REG_ON_THRESH:  r_cfg.on_threshold  <= i_cfg.data[LEVEL_W-1:0];
                REG_MOVE_DELAY: r_cfg.move_delay_ms <= i_cfg.data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    dsss_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    dsss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dsss_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_result  (o_result)
    );

endmodule
